/* hw/rtl/jcls_pkg.sv */
// Package for the joystick code lock with stepper: widths, constants,
// register map, entry codes, result struct and lookup functions.
// Used by joystick_code_lock_with_stepper_unit; depends on nothing.
`default_nettype none

package jcls_pkg;

  localparam int CODE_LENGTH = 4;
  localparam int SAMPLE_BITS = 10;
  localparam int IDX_W       = $clog2(CODE_LENGTH + 1);
  localparam int POS_W       = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam int CODE_W      = 3;
  localparam int STEPS_W     = 10;
  localparam int ERR_W       = 12;
  localparam int BLINK_W     = 10;
  localparam int ADDR_W      = 5;

  // LED timing, in milliseconds per scheduled update
  localparam logic [ERR_W-1:0]   ERR_STEP   = ERR_W'(50);
  localparam logic [ERR_W-1:0]   ERR_LEN    = ERR_W'(4000);
  localparam logic [BLINK_W-1:0] BLINK_STEP = BLINK_W'(50);
  localparam logic [BLINK_W-1:0] BLINK_HALF = BLINK_W'(500);

  // Register map: word index in paddr[4:2]
  localparam logic [2:0] REG_HIGH_THR   = 3'd0;
  localparam logic [2:0] REG_LOW_THR    = 3'd1;
  localparam logic [2:0] REG_CODE_FIRST = 3'd2;
  localparam logic [2:0] REG_CODE_SEC   = 3'd3;
  localparam logic [2:0] REG_CODE_THIRD = 3'd4;
  localparam logic [2:0] REG_CODE_FOUR  = 3'd5;
  localparam logic [2:0] REG_MOVE_STEPS = 3'd6;

  // Direction codes
  localparam logic [2:0] DIR_CENTRE = 3'd0;
  localparam logic [2:0] DIR_RIGHT  = 3'd1;
  localparam logic [2:0] DIR_DOWN   = 3'd2;
  localparam logic [2:0] DIR_LEFT   = 3'd3;
  localparam logic [2:0] DIR_UP     = 3'd4;

  // Entry sequencer codes
  localparam logic [1:0] ENT_WAIT_CENTRE  = 2'd0;
  localparam logic [1:0] ENT_WAIT_RELEASE = 2'd1;
  localparam logic [1:0] ENT_PROCESS      = 2'd2;

  localparam logic [3:0] TICK_LAST = 4'd9;
  localparam logic [3:0] TICK_MID  = 4'd5;

  typedef struct packed {
    logic [3:0] coil;
    logic [1:0] led;
    logic [7:0] segment;
    logic [2:0] direction;
    logic       locked;
    logic       running;
  } result_t;

  function automatic logic [7:0] seg_lookup(input logic [2:0] dir);
    logic [7:0] seg;
    unique case (dir)
      DIR_RIGHT: seg = 8'b0111_1100;
      DIR_DOWN:  seg = 8'b0000_1001;
      DIR_LEFT:  seg = 8'b0111_1001;
      DIR_UP:    seg = 8'b0001_1100;
      default:   seg = 8'b0000_0001;
    endcase
    return seg;
  endfunction

  function automatic logic [3:0] coil_lookup(input logic [1:0] step);
    logic [3:0] coil;
    unique case (step)
      2'd0:    coil = 4'b0001;
      2'd1:    coil = 4'b0010;
      2'd2:    coil = 4'b0100;
      default: coil = 4'b1000;
    endcase
    return coil;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/joystick_code_lock_with_stepper_unit.sv */
// Joystick code lock with stepper latch: tick scheduler, direction classifier,
// code entry, LED status, wave-drive stepper and APB register file.
// Depends on jcls_pkg.
//
//   channel   direction  handshake                 payload
//   in        sink       in_valid_i / in_stall_o   x_sample_i, y_sample_i
//   out       source     out_valid_o / out_stall_i coil, led, segment, direction,
//                                                  is_locked, motor_running
//   config    APB slave  psel/penable/pwrite       paddr, pwdata, prdata
//
// One item per cycle while in_stall_o is low: the whole tick update is done in
// the accept cycle, and the result is registered in the output or skid register.
// A two-entry output (result register plus skid register) lets an item be taken
// while the previous result is stalled; in_stall_o rises only when both are full.
// Reset is asynchronous and puts the lock in the locked state with the motor idle.
`default_nettype none

module joystick_code_lock_with_stepper_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [jcls_pkg::SAMPLE_BITS-1:0] x_sample_i,
  input  wire logic [jcls_pkg::SAMPLE_BITS-1:0] y_sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [3:0]                         coil_pattern_o,
  output logic [1:0]                         led_pattern_o,
  output logic [7:0]                         segment_pattern_o,
  output logic [2:0]                         joy_direction_o,
  output logic                               is_locked_o,
  output logic                               motor_running_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [jcls_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  import jcls_pkg::*;

  // configuration
  logic [SAMPLE_BITS-1:0] high_thr_q, low_thr_q;
  logic [CODE_W-1:0]      code_q [4];
  logic [STEPS_W-1:0]     move_steps_q;

  // tick state
  logic [3:0]         tick_q, tick_d;
  logic [2:0]         dir_q, dir_d;
  logic [1:0]         entry_st_q, entry_st_d;
  logic [CODE_W-1:0]  entry_buf_q [CODE_LENGTH];
  logic [IDX_W-1:0]   entry_idx_q, entry_idx_d;
  logic               buf_we;
  logic               locked_q, locked_d;
  logic               reverse_q, reverse_d;
  logic               request_q, request_d;
  logic               busy_q, busy_d;
  logic [2:0]         phase_q, phase_d;
  logic [STEPS_W-1:0] steps_q, steps_d;
  logic               err_q, err_d;
  logic [ERR_W-1:0]   err_time_q, err_time_d;
  logic [BLINK_W-1:0] blink_time_q, blink_time_d;
  logic               blink_q, blink_d;
  logic [3:0]         coil_q, coil_d;
  logic [7:0]         seg_q, seg_d;
  logic [1:0]         led_q, led_d;

  // output register and skid
  result_t res_d, out_q, skid_q;
  logic    out_vld_q, skid_vld_q;
  logic    in_acc, out_free;

  logic cfg_we;
  logic main_slot;
  logic code_ok;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_thr_q   <= SAMPLE_BITS'(800);
      low_thr_q    <= SAMPLE_BITS'(200);
      code_q[0]    <= DIR_RIGHT;
      code_q[1]    <= DIR_LEFT;
      code_q[2]    <= DIR_UP;
      code_q[3]    <= DIR_DOWN;
      move_steps_q <= STEPS_W'(512);
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        REG_HIGH_THR:   high_thr_q   <= pwdata[SAMPLE_BITS-1:0];
        REG_LOW_THR:    low_thr_q    <= pwdata[SAMPLE_BITS-1:0];
        REG_CODE_FIRST: code_q[0]    <= pwdata[CODE_W-1:0];
        REG_CODE_SEC:   code_q[1]    <= pwdata[CODE_W-1:0];
        REG_CODE_THIRD: code_q[2]    <= pwdata[CODE_W-1:0];
        REG_CODE_FOUR:  code_q[3]    <= pwdata[CODE_W-1:0];
        REG_MOVE_STEPS: move_steps_q <= pwdata[STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_HIGH_THR:   prdata = 32'(high_thr_q);
      REG_LOW_THR:    prdata = 32'(low_thr_q);
      REG_CODE_FIRST: prdata = 32'(code_q[0]);
      REG_CODE_SEC:   prdata = 32'(code_q[1]);
      REG_CODE_THIRD: prdata = 32'(code_q[2]);
      REG_CODE_FOUR:  prdata = 32'(code_q[3]);
      REG_MOVE_STEPS: prdata = 32'(move_steps_q);
      default:        prdata = 32'd0;
    endcase
  end

  assign in_stall_o = skid_vld_q;
  assign in_acc     = in_valid_i & ~skid_vld_q;
  assign main_slot  = (tick_q == 4'd0) || (tick_q == TICK_MID);

  // compare every position against its code register
  always_comb begin
    code_ok = 1'b1;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (entry_buf_q[i] != code_q[i % 4]) code_ok = 1'b0;
    end
  end

  always_comb begin
    logic [ERR_W-1:0]   err_sum;
    logic [BLINK_W-1:0] blink_sum;
    logic               blink_tmp;

    tick_d       = (tick_q >= TICK_LAST) ? 4'd0 : tick_q + 4'd1;
    dir_d        = dir_q;
    seg_d        = seg_q;
    entry_st_d   = entry_st_q;
    entry_idx_d  = entry_idx_q;
    buf_we       = 1'b0;
    locked_d     = locked_q;
    reverse_d    = reverse_q;
    request_d    = request_q;
    err_d        = err_q;
    err_time_d   = err_time_q;
    blink_time_d = blink_time_q;
    blink_d      = blink_q;
    led_d        = led_q;
    busy_d       = busy_q;
    phase_d      = phase_q;
    steps_d      = steps_q;
    coil_d       = coil_q;
    err_sum      = '0;
    blink_sum    = '0;
    blink_tmp    = 1'b0;

    if (main_slot) begin
      priority if (x_sample_i > high_thr_q) dir_d = DIR_RIGHT;
      else if (x_sample_i < low_thr_q)      dir_d = DIR_LEFT;
      else if (y_sample_i > high_thr_q)     dir_d = DIR_DOWN;
      else if (y_sample_i < low_thr_q)      dir_d = DIR_UP;
      else                                  dir_d = DIR_CENTRE;
    end
    if (tick_q == 4'd0) seg_d = seg_lookup(dir_d);

    if (main_slot) begin
      // code entry
      unique case (entry_st_q)
        ENT_WAIT_RELEASE: begin
          if (dir_d == DIR_CENTRE) begin
            entry_idx_d = entry_idx_q + IDX_W'(1);
            entry_st_d  = (entry_idx_d >= IDX_W'(CODE_LENGTH)) ? ENT_PROCESS
                                                               : ENT_WAIT_CENTRE;
          end
        end
        ENT_PROCESS: begin
          if (code_ok) begin
            locked_d  = ~locked_q;
            reverse_d = ~locked_q;
            request_d = 1'b1;
          end else begin
            err_d        = 1'b1;
            err_time_d   = '0;
            blink_time_d = '0;
          end
          entry_idx_d = '0;
          entry_st_d  = ENT_WAIT_CENTRE;
        end
        default: begin
          if (dir_d != DIR_CENTRE) begin
            buf_we     = (entry_idx_q < IDX_W'(CODE_LENGTH));
            entry_st_d = ENT_WAIT_RELEASE;
          end
        end
      endcase

      // LEDs: motor first, then error blink, then entry count
      priority if (busy_q) begin
        led_d = 2'b11;
      end else if (err_d) begin
        err_sum   = err_time_d + ERR_STEP;
        blink_sum = blink_time_d + BLINK_STEP;
        blink_tmp = blink_d;
        if (blink_sum >= BLINK_HALF) begin
          blink_sum = blink_sum - BLINK_HALF;
          blink_tmp = ~blink_tmp;
        end
        err_time_d   = err_sum;
        blink_time_d = blink_sum;
        blink_d      = blink_tmp;
        led_d        = blink_tmp ? 2'b11 : 2'b00;
        if (err_sum >= ERR_LEN) begin
          err_d = 1'b0;
          led_d = 2'b00;
        end
      end else begin
        led_d = (entry_idx_d >= IDX_W'(1) && entry_idx_d <= IDX_W'(3))
                ? entry_idx_d[1:0] : 2'b00;
      end
    end

    // stepper, every tick
    if (!busy_q) begin
      if (request_d) begin
        request_d = 1'b0;
        busy_d    = 1'b1;
        steps_d   = move_steps_q;
      end
    end else begin
      coil_d  = coil_lookup(phase_q[2:1]);
      phase_d = reverse_d ? phase_q + 3'd6 : phase_q + 3'd2;
      if (steps_q <= STEPS_W'(1)) begin
        steps_d = '0;
        busy_d  = 1'b0;
      end else begin
        steps_d = steps_q - STEPS_W'(1);
      end
    end

    res_d.coil      = coil_d;
    res_d.led       = led_d;
    res_d.segment   = seg_d;
    res_d.direction = dir_d;
    res_d.locked    = locked_d;
    res_d.running   = busy_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q       <= '0;
      dir_q        <= DIR_CENTRE;
      entry_st_q   <= ENT_WAIT_CENTRE;
      entry_idx_q  <= '0;
      locked_q     <= 1'b1;
      reverse_q    <= 1'b0;
      request_q    <= 1'b0;
      busy_q       <= 1'b0;
      phase_q      <= '0;
      steps_q      <= '0;
      err_q        <= 1'b0;
      err_time_q   <= '0;
      blink_time_q <= '0;
      blink_q      <= 1'b0;
      coil_q       <= '0;
      seg_q        <= '0;
      led_q        <= '0;
    end else if (in_acc) begin
      tick_q       <= tick_d;
      dir_q        <= dir_d;
      entry_st_q   <= entry_st_d;
      entry_idx_q  <= entry_idx_d;
      locked_q     <= locked_d;
      reverse_q    <= reverse_d;
      request_q    <= request_d;
      busy_q       <= busy_d;
      phase_q      <= phase_d;
      steps_q      <= steps_d;
      err_q        <= err_d;
      err_time_q   <= err_time_d;
      blink_time_q <= blink_time_d;
      blink_q      <= blink_d;
      coil_q       <= coil_d;
      seg_q        <= seg_d;
      led_q        <= led_d;
    end
  end

  // entry buffer: one write port, every entry read at its own place
  always_ff @(posedge clk_i) begin
    if (in_acc && buf_we) entry_buf_q[entry_idx_q[POS_W-1:0]] <= dir_d;
  end

  // output register with skid: park the new item when the result is stalled
  assign out_free = ~out_vld_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q  <= skid_vld_q | in_acc;
      skid_vld_q <= 1'b0;
    end else if (in_acc) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_vld_q ? skid_q : res_d;
    end else if (in_acc) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign coil_pattern_o    = out_q.coil;
  assign led_pattern_o     = out_q.led;
  assign segment_pattern_o = out_q.segment;
  assign joy_direction_o   = out_q.direction;
  assign is_locked_o       = out_q.locked;
  assign motor_running_o   = out_q.running;

endmodule

`default_nettype wire

/* tb/tb_joystick_code_lock_with_stepper_unit.sv */
// Testbench for joystick_code_lock_with_stepper_unit: joystick ticks are driven
// through the valid/stall input, and every status item is checked against an
// in-bench model of the lock. Depends on jcls_pkg and the unit RTL.
module tb_joystick_code_lock_with_stepper_unit;
  import jcls_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int MS_PER_SLOT   = 50;
  localparam int BLINK_HALF_MS = 500;
  localparam int ERROR_SPAN_MS = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [SAMPLE_BITS-1:0] x_sample_i = '0;
  logic [SAMPLE_BITS-1:0] y_sample_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [3:0]             coil_pattern_o;
  logic [1:0]             led_pattern_o;
  logic [7:0]             segment_pattern_o;
  logic [2:0]             joy_direction_o;
  logic                   is_locked_o;
  logic                   motor_running_o;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [ADDR_W-1:0]      paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;

  // Lock settings as last written
  logic [9:0] thr_hi = 10'd800;
  logic [9:0] thr_lo = 10'd200;
  logic [2:0] code_q [4] = '{3'd1, 3'd3, 3'd4, 3'd2};
  logic [9:0] steps_cfg = 10'd512;

  // Lock state
  logic [3:0] tick_q = '0;
  logic [2:0] dir_q = DIR_CENTRE;
  logic [1:0] entry_q = ENT_WAIT_CENTRE;
  logic [2:0] entry_buf [CODE_LENGTH];
  int         entry_cnt = 0;
  logic       lock_q = 1'b1;
  logic       rev_q = 1'b0;
  logic       move_pending = 1'b0;
  logic       motor_on = 1'b0;
  logic [2:0] phase_q = '0;
  int         steps_q = 0;
  logic       err_on = 1'b0;
  int         err_ms = 0;
  int         blink_ms = 0;
  logic       blink_lit = 1'b0;
  logic [3:0] coil_q = '0;
  logic [7:0] seg_q = '0;
  logic [1:0] led_q = '0;

  logic [7:0] seg_by_dir [5] = '{8'h01, 8'h7C, 8'h09, 8'h79, 8'h1C};
  logic [3:0] coil_one_hot [4] = '{4'b0001, 4'b0010, 4'b0100, 4'b1000};

  result_t status_due [$];
  result_t want_status;
  int      fault_count = 0;
  int      cycle_count = 0;
  int      ticks_sent = 0;
  int      stall_left = 0;
  bit      idle_bursts = 1'b0;

  joystick_code_lock_with_stepper_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .x_sample_i        (x_sample_i),
    .y_sample_i        (y_sample_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .coil_pattern_o    (coil_pattern_o),
    .led_pattern_o     (led_pattern_o),
    .segment_pattern_o (segment_pattern_o),
    .joy_direction_o   (joy_direction_o),
    .is_locked_o       (is_locked_o),
    .motor_running_o   (motor_running_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_joystick_code_lock_with_stepper_unit NOT OK");
      $finish;
    end
  end

  // One tick of the lock: classify, segment, code entry, LEDs, stepper
  function automatic result_t advance_lock(input logic [9:0] sx, input logic [9:0] sy);
    result_t r;
    logic    hit;
    logic    main_slot;
    main_slot = (tick_q == 4'd0) || (tick_q == TICK_MID);
    if (main_slot) begin
      if (sx > thr_hi) dir_q = DIR_RIGHT;
      else if (sx < thr_lo) dir_q = DIR_LEFT;
      else if (sy > thr_hi) dir_q = DIR_DOWN;
      else if (sy < thr_lo) dir_q = DIR_UP;
      else dir_q = DIR_CENTRE;
    end
    if (tick_q == 4'd0) seg_q = seg_by_dir[dir_q];
    if (main_slot) begin
      case (entry_q)
        ENT_WAIT_RELEASE: begin
          if (dir_q == DIR_CENTRE) begin
            entry_cnt++;
            entry_q = (entry_cnt >= CODE_LENGTH) ? ENT_PROCESS : ENT_WAIT_CENTRE;
          end
        end
        ENT_PROCESS: begin
          hit = 1'b1;
          for (int i = 0; i < CODE_LENGTH; i++)
            if (entry_buf[i] != code_q[i % 4]) hit = 1'b0;
          if (hit) begin
            lock_q = !lock_q;
            rev_q = lock_q;
            move_pending = 1'b1;
          end else begin
            err_on = 1'b1;
            err_ms = 0;
            blink_ms = 0;
          end
          entry_cnt = 0;
          entry_q = ENT_WAIT_CENTRE;
        end
        default: begin
          if (dir_q != DIR_CENTRE) begin
            if (entry_cnt < CODE_LENGTH) entry_buf[entry_cnt] = dir_q;
            entry_q = ENT_WAIT_RELEASE;
          end
        end
      endcase
      // motor beats error display; error timers freeze while it runs
      if (motor_on) begin
        led_q = 2'b11;
      end else if (err_on) begin
        err_ms += MS_PER_SLOT;
        blink_ms += MS_PER_SLOT;
        if (blink_ms >= BLINK_HALF_MS) begin
          blink_ms -= BLINK_HALF_MS;
          blink_lit = !blink_lit;
        end
        led_q = blink_lit ? 2'b11 : 2'b00;
        if (err_ms >= ERROR_SPAN_MS) begin
          err_on = 1'b0;
          led_q = 2'b00;
        end
      end else begin
        led_q = (entry_cnt >= 1 && entry_cnt <= 3) ? 2'(entry_cnt) : 2'b00;
      end
    end
    if (!motor_on) begin
      if (move_pending) begin
        move_pending = 1'b0;
        motor_on = 1'b1;
        steps_q = steps_cfg;
      end
    end else begin
      coil_q = coil_one_hot[phase_q[2:1]];
      phase_q = rev_q ? phase_q + 3'd6 : phase_q + 3'd2;
      if (steps_q <= 1) begin
        steps_q = 0;
        motor_on = 1'b0;
      end else begin
        steps_q--;
      end
    end
    tick_q = (tick_q >= TICK_LAST) ? 4'd0 : tick_q + 4'd1;
    r.coil = coil_q;
    r.led = led_q;
    r.segment = seg_q;
    r.direction = dir_q;
    r.locked = lock_q;
    r.running = motor_on;
    return r;
  endfunction

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= 100) $display("[cycle %0d] %s", cycle_count, msg);
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want) note_fault($sformatf("%s: got %0d, want %0d", name, got, want));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (status_due.size() == 0) begin
        note_fault("status item arrived with none pending");
      end else begin
        want_status = status_due.pop_front();
        compare_field("coil_pattern", coil_pattern_o, want_status.coil);
        compare_field("led_pattern", led_pattern_o, want_status.led);
        compare_field("segment_pattern", segment_pattern_o, want_status.segment);
        compare_field("joy_direction", joy_direction_o, want_status.direction);
        compare_field("is_locked", is_locked_o, want_status.locked);
        compare_field("motor_running", motor_running_o, want_status.running);
      end
    end
  end

  // Output back-pressure in bursts
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
    end else if (idle_bursts && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 11);
    end
    out_stall_i = (stall_left != 0);
  end

  task automatic send_tick(input logic [9:0] x, input logic [9:0] y);
    int gap;
    @(negedge clk_i);
    if (idle_bursts && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    x_sample_i = x;
    y_sample_i = y;
    do @(posedge clk_i); while (in_stall_o);
    status_due.push_back(advance_lock(x, y));
    ticks_sent++;
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_HIGH_THR:   thr_hi = value[9:0];
      REG_LOW_THR:    thr_lo = value[9:0];
      REG_CODE_FIRST: code_q[0] = value[2:0];
      REG_CODE_SEC:   code_q[1] = value[2:0];
      REG_CODE_THIRD: code_q[2] = value[2:0];
      REG_CODE_FOUR:  code_q[3] = value[2:0];
      REG_MOVE_STEPS: steps_cfg = value[9:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic write_codes(input logic [2:0] c0, input logic [2:0] c1,
                             input logic [2:0] c2, input logic [2:0] c3);
    write_reg(REG_CODE_FIRST, c0);
    write_reg(REG_CODE_SEC, c1);
    write_reg(REG_CODE_THIRD, c2);
    write_reg(REG_CODE_FOUR, c3);
  endtask

  function automatic logic [9:0] edge_or_any();
    case ($urandom_range(0, 3))
      0: return 10'd0;
      1: return 10'h3FF;
      default: return 10'($urandom);
    endcase
  endfunction

  // Samples that land in the given direction under the current thresholds
  task automatic pick_samples(input logic [2:0] d, output logic [9:0] x,
                              output logic [9:0] y);
    logic [9:0] mid_x, mid_y;
    x = 10'($urandom);
    y = 10'($urandom);
    mid_x = x;
    mid_y = y;
    if (thr_lo <= thr_hi) begin
      mid_x = 10'($urandom_range(thr_lo, thr_hi));
      mid_y = 10'($urandom_range(thr_lo, thr_hi));
    end
    case (d)
      DIR_RIGHT: if (thr_hi != 10'h3FF) x = 10'($urandom_range(thr_hi + 1, 1023));
      DIR_LEFT:  if (thr_lo != 10'd0) x = 10'($urandom_range(0, thr_lo - 1));
      DIR_DOWN: begin
        x = mid_x;
        if (thr_hi != 10'h3FF) y = 10'($urandom_range(thr_hi + 1, 1023));
      end
      DIR_UP: begin
        x = mid_x;
        if (thr_lo != 10'd0) y = 10'($urandom_range(0, thr_lo - 1));
      end
      default: begin
        x = mid_x;
        y = mid_y;
      end
    endcase
  endtask

  // Pad with noise up to the next classifying tick, then send the sample there
  task automatic send_on_slot(input logic [9:0] x, input logic [9:0] y);
    while (!(tick_q == 4'd0 || tick_q == TICK_MID)) send_tick(edge_or_any(), edge_or_any());
    send_tick(x, y);
  endtask

  task automatic hold_dir(input logic [2:0] d, input int slots);
    logic [9:0] x, y;
    repeat (slots) begin
      pick_samples(d, x, y);
      send_on_slot(x, y);
    end
  endtask

  function automatic logic [3*CODE_LENGTH-1:0] lock_code();
    logic [3*CODE_LENGTH-1:0] c;
    for (int i = 0; i < CODE_LENGTH; i++) c[3*i +: 3] = code_q[i % 4];
    return c;
  endfunction

  function automatic logic [3*CODE_LENGTH-1:0] random_digits();
    logic [3*CODE_LENGTH-1:0] c;
    for (int i = 0; i < CODE_LENGTH; i++) c[3*i +: 3] = 3'($urandom_range(1, 4));
    return c;
  endfunction

  function automatic logic [3*CODE_LENGTH-1:0] wrong_code();
    logic [3*CODE_LENGTH-1:0] c;
    int pos;
    c = lock_code();
    pos = $urandom_range(0, CODE_LENGTH - 1);
    c[3*pos +: 3] = 3'((c[3*pos +: 3] % 4) + 1);
    return c;
  endfunction

  // Press and release each remaining digit, then give the checking slot
  task automatic enter_code(input logic [3*CODE_LENGTH-1:0] digits);
    while (entry_q != ENT_WAIT_CENTRE) hold_dir(DIR_CENTRE, 1);
    for (int i = entry_cnt; i < CODE_LENGTH; i++) begin
      hold_dir(digits[3*i +: 3], $urandom_range(1, 2));
      hold_dir(DIR_CENTRE, $urandom_range(1, 2));
    end
    hold_dir(3'($urandom_range(0, 4)), 1);
  endtask

  task automatic finish_moves();
    while (motor_on || move_pending) hold_dir(DIR_CENTRE, 1);
  endtask

  task automatic run_random_episode();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      enter_code(lock_code());
    end else if (pick < 6) begin
      enter_code($urandom_range(0, 1) ? random_digits() : wrong_code());
    end else if (pick < 8) begin
      repeat ($urandom_range(1, 12)) send_tick(edge_or_any(), edge_or_any());
    end else if (pick == 8) begin
      // broken entry: presses with missing releases, then noise
      repeat ($urandom_range(1, 3)) begin
        hold_dir(3'($urandom_range(1, 4)), 1);
        hold_dir(DIR_CENTRE, $urandom_range(0, 1));
      end
      repeat ($urandom_range(1, 8)) send_tick(edge_or_any(), edge_or_any());
    end else begin
      wait_drain();
    end
  endtask

  // Reset settings; boundaries and priority of the direction classifier
  task automatic test_direction_classes();
    idle_bursts = 1'b0;
    send_on_slot(10'd1023, 10'd1023);
    send_on_slot(10'd0, 10'd0);
    send_on_slot(10'd0, 10'd1023);
    send_on_slot(10'd801, 10'd0);
    send_on_slot(10'd800, 10'd1023);
    send_on_slot(10'd800, 10'd801);
    send_on_slot(10'd200, 10'd0);
    send_on_slot(10'd199, 10'd500);
    send_on_slot(10'd500, 10'd199);
    send_on_slot(10'd800, 10'd800);
    send_on_slot(10'd200, 10'd200);
    send_on_slot(10'd1023, 10'd0);
  endtask

  task automatic test_threshold_extremes();
    logic [9:0] hi_set [5] = '{10'd1023, 10'd0, 10'd0, 10'd1023, 10'd512};
    logic [9:0] lo_set [5] = '{10'd0, 10'd1023, 10'd0, 10'd1023, 10'd511};
    idle_bursts = 1'b1;
    for (int i = 0; i < 5; i++) begin
      wait_drain();
      write_reg(REG_HIGH_THR, hi_set[i]);
      write_reg(REG_LOW_THR, lo_set[i]);
      repeat (2) send_on_slot(edge_or_any(), edge_or_any());
    end
    wait_drain();
    write_reg(REG_HIGH_THR, 32'd800);
    write_reg(REG_LOW_THR, 32'd200);
  endtask

  // Unlock and relock with short moves, zero steps among them
  task automatic test_lock_and_unlock();
    int steps_pick;
    wait_drain();
    write_codes(3'($urandom_range(1, 4)), 3'($urandom_range(1, 4)),
                3'($urandom_range(1, 4)), 3'($urandom_range(1, 4)));
    for (int i = 0; i < 3; i++) begin
      steps_pick = (i < 2) ? i : $urandom_range(2, 30);
      wait_drain();
      write_reg(REG_MOVE_STEPS, steps_pick);
      enter_code(lock_code());
      finish_moves();
    end
  endtask

  // Wrong code, restart of the error, then let the blink run out
  task automatic test_error_display();
    enter_code(wrong_code());
    hold_dir(DIR_CENTRE, 4);
    enter_code(wrong_code());
    while (err_on) hold_dir(DIR_CENTRE, 1);
    hold_dir(DIR_CENTRE, 2);
  endtask

  task automatic test_invalid_code_regs();
    wait_drain();
    write_codes(3'd0, 3'd5, 3'd6, 3'd7);
    enter_code(random_digits());
    wait_drain();
    write_codes(3'($urandom_range(1, 4)), 3'($urandom_range(1, 4)),
                3'($urandom_range(1, 4)), 3'($urandom_range(1, 4)));
  endtask

  // Toggle and error while the motor is running
  task automatic test_entry_during_move();
    wait_drain();
    write_reg(REG_MOVE_STEPS, 32'd120);
    enter_code(lock_code());
    enter_code(lock_code());
    enter_code(wrong_code());
    finish_moves();
  endtask

  task automatic test_long_move();
    wait_drain();
    write_reg(REG_MOVE_STEPS, 32'd150);
    enter_code(lock_code());
    enter_code(wrong_code());
    finish_moves();
  endtask

  task automatic test_random_traffic();
    int          stop_at;
    int unsigned lo;
    for (int phase = 0; phase < 3; phase++) begin
      wait_drain();
      lo = $urandom_range(1, 500);
      write_reg(REG_HIGH_THR, $urandom_range(lo + 1, 1022));
      write_reg(REG_LOW_THR, lo);
      for (int i = 0; i < 4; i++)
        write_reg(3'(REG_CODE_FIRST + i),
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4));
      write_reg(REG_MOVE_STEPS, $urandom_range(0, 40));
      idle_bursts = (phase != 1);
      stop_at = ticks_sent + 30;
      while (ticks_sent < stop_at) run_random_episode();
    end
  endtask

  task automatic test_steady_tail();
    int stop_at;
    idle_bursts = 1'b0;
    stop_at = ticks_sent + 30;
    while (ticks_sent < stop_at) run_random_episode();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_direction_classes();
    test_threshold_extremes();
    test_lock_and_unlock();
    test_error_display();
    test_invalid_code_regs();
    test_entry_during_move();
    test_long_move();
    test_random_traffic();
    test_steady_tail();
    wait_drain();
    repeat (8) @(posedge clk_i);
    if (fault_count == 0)
      $display("tb_joystick_code_lock_with_stepper_unit OK");
    else
      $display("tb_joystick_code_lock_with_stepper_unit NOT OK");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/jcls_pkg.sv
hw/rtl/joystick_code_lock_with_stepper_unit.sv
tb/tb_joystick_code_lock_with_stepper_unit.sv
